FILE: src/clns_pkg.sv
package clns_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned PHASE_W    = 5;

   typedef enum logic [2:0] {
      MODE_INIT    = 3'd0,
      MODE_COMMAND = 3'd1,
      MODE_DATA    = 3'd2,
      MODE_CLEAR   = 3'd3,
      MODE_HOME    = 3'd4,
      MODE_CURSOR  = 3'd5
   } mode_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_FUNCTION_SET    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DISPLAY_CONTROL = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRY_MODE      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLEAR           = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOME            = 3'd4;

   localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
   localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0E;
   localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;
   localparam logic [7:0] RST_CLEAR           = 8'h01;
   localparam logic [7:0] RST_HOME            = 8'h02;

   localparam logic [7:0] ROW1_BASE = 8'h80;
   localparam logic [7:0] ROW2_BASE = 8'hC0;
   localparam logic [1:0] ROW_ONE   = 2'd1;
   localparam logic [1:0] ROW_TWO   = 2'd2;

   localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

   localparam logic [15:0] EN_HIGH_US     = 16'd10;
   localparam logic [15:0] EN_LOW_US      = 16'd100;
   localparam logic [15:0] LONG_LOW_US    = 16'd2100;
   localparam logic [15:0] POWER_UP_US    = 16'd40000;
   localparam logic [15:0] WAKE1_LOW_US   = 16'd5100;
   localparam logic [15:0] WAKE2_LOW_US   = 16'd250;

   // init: phase 0 power-up wait, 1..8 wake nibbles, 9..24 four bytes
   localparam logic [PHASE_W-1:0] INIT_LAST_PHASE  = 5'd24;
   localparam logic [PHASE_W-1:0] INIT_BYTE_PHASE  = 5'd9;
   localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE  = 5'd3;

   localparam logic [1:0] INIT_BYTE_FUNC  = 2'd0;
   localparam logic [1:0] INIT_BYTE_DISP  = 2'd1;
   localparam logic [1:0] INIT_BYTE_CLEAR = 2'd2;
   localparam logic [1:0] INIT_BYTE_ENTRY = 2'd3;

   typedef struct packed {
      logic [7:0] function_set;
      logic [7:0] display_control;
      logic [7:0] entry_mode;
      logic [7:0] clear;
      logic [7:0] home;
   } cfg_type;

   typedef struct packed {
      logic       is_init;
      logic       reg_select;
      logic       long_hold;
      logic [7:0] byte_value;
   } job_type;

   typedef struct packed {
      logic        reg_select;
      logic        read_write;
      logic        enable_pin;
      logic [3:0]  bus_nibble;
      logic [15:0] hold_us;
      logic        last;
   } pin_type;

endpackage

FILE: src/clns_front.sv
module clns_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [clns_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  clns_pkg::cfg_type                   cfg,
   output logic                                job_valid,
   input  logic                                job_ready,
   output clns_pkg::job_type                   job
);

   logic              valid_ff, valid_in;
   clns_pkg::job_type job_ff, job_in;
   logic [2:0]        mode;
   logic [7:0]        byte_value;
   logic [1:0]        cursor_row;
   logic [7:0]        cursor_col;
   logic [7:0]        cursor_addr;
   logic              known;
   logic              accept;

   assign mode       = req_tdata[2:0];
   assign byte_value = req_tdata[10:3];
   assign cursor_row = req_tdata[12:11];
   assign cursor_col = req_tdata[20:13];

   assign req_tready = !valid_ff || job_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cursor_addr = cursor_col - 8'd1;
      if (cursor_row == clns_pkg::ROW_ONE) begin
         cursor_addr = cursor_addr | clns_pkg::ROW1_BASE;
      end else if (cursor_row == clns_pkg::ROW_TWO) begin
         cursor_addr = cursor_addr | clns_pkg::ROW2_BASE;
      end
   end

   // classify the request into one job for the back end; drop unused modes
   always_comb begin
      known              = 1'b1;
      job_in.is_init     = 1'b0;
      job_in.reg_select  = 1'b0;
      job_in.long_hold   = 1'b0;
      job_in.byte_value  = byte_value;
      case (mode)
         clns_pkg::MODE_INIT: begin
            job_in.is_init = 1'b1;
         end
         clns_pkg::MODE_COMMAND: begin
         end
         clns_pkg::MODE_DATA: begin
            job_in.reg_select = 1'b1;
         end
         clns_pkg::MODE_CLEAR: begin
            job_in.long_hold  = 1'b1;
            job_in.byte_value = cfg.clear;
         end
         clns_pkg::MODE_HOME: begin
            job_in.long_hold  = 1'b1;
            job_in.byte_value = cfg.home;
         end
         clns_pkg::MODE_CURSOR: begin
            job_in.byte_value = cursor_addr;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = known;
      end else if (job_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

FILE: src/clns_queue.sv
module clns_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  clns_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output clns_pkg::job_type pop_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   clns_pkg::job_type slots [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/clns_back.sv
module clns_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  clns_pkg::job_type job,
   input  clns_pkg::cfg_type cfg,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output clns_pkg::pin_type pins
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   clns_pkg::job_type             job_ff;
   logic [clns_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic                          out_valid_ff, out_valid_in;
   clns_pkg::pin_type             pins_ff, pins_in;
   logic                          emit;
   logic [clns_pkg::PHASE_W-1:0]  wake_idx;
   logic [clns_pkg::PHASE_W-1:0]  byte_phase;
   logic [7:0]                    cur_byte;
   logic                          cur_long;

   assign emit      = (state_ff == S_RUN) && (!out_valid_ff || rsp_tready);
   assign job_ready = state_ff == S_IDLE;
   assign wake_idx  = phase_ff - clns_pkg::PHASE_W'(1);

   always_comb begin
      byte_phase = phase_ff;
      cur_byte   = job_ff.byte_value;
      cur_long   = job_ff.long_hold;
      if (job_ff.is_init) begin
         byte_phase = phase_ff - clns_pkg::INIT_BYTE_PHASE;
         cur_long   = byte_phase[3:2] == clns_pkg::INIT_BYTE_CLEAR;
         case (byte_phase[3:2])
            clns_pkg::INIT_BYTE_FUNC:  cur_byte = cfg.function_set;
            clns_pkg::INIT_BYTE_DISP:  cur_byte = cfg.display_control;
            clns_pkg::INIT_BYTE_CLEAR: cur_byte = cfg.clear;
            default:                   cur_byte = cfg.entry_mode;
         endcase
      end
   end

   // one pin update per phase: enable high then low, high nibble first
   always_comb begin
      pins_in.reg_select = job_ff.reg_select;
      pins_in.read_write = 1'b0;
      pins_in.enable_pin = !byte_phase[0];
      pins_in.bus_nibble = byte_phase[1] ? cur_byte[3:0] : cur_byte[7:4];
      if (!byte_phase[0]) begin
         pins_in.hold_us = clns_pkg::EN_HIGH_US;
      end else if (cur_long && byte_phase[1]) begin
         pins_in.hold_us = clns_pkg::LONG_LOW_US;
      end else begin
         pins_in.hold_us = clns_pkg::EN_LOW_US;
      end
      pins_in.last = phase_ff == clns_pkg::BYTE_LAST_PHASE;
      if (job_ff.is_init) begin
         pins_in.last = phase_ff == clns_pkg::INIT_LAST_PHASE;
         if (phase_ff == '0) begin
            pins_in.reg_select = 1'b0;
            pins_in.enable_pin = 1'b0;
            pins_in.bus_nibble = '0;
            pins_in.hold_us    = clns_pkg::POWER_UP_US;
         end else if (phase_ff < clns_pkg::INIT_BYTE_PHASE) begin
            pins_in.enable_pin = !wake_idx[0];
            pins_in.bus_nibble = (wake_idx[2:1] == 2'd3) ? clns_pkg::FOUR_BIT_NIB
                                                          : clns_pkg::WAKE_NIBBLE;
            if (!wake_idx[0]) begin
               pins_in.hold_us = clns_pkg::EN_HIGH_US;
            end else if (wake_idx[2:1] == 2'd0) begin
               pins_in.hold_us = clns_pkg::WAKE1_LOW_US;
            end else if (wake_idx[2:1] == 2'd1) begin
               pins_in.hold_us = clns_pkg::WAKE2_LOW_US;
            end else begin
               pins_in.hold_us = clns_pkg::EN_LOW_US;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               state_in = S_RUN;
               phase_in = '0;
            end
         end
         S_RUN: begin
            if (emit) begin
               out_valid_in = 1'b1;
               phase_in     = phase_ff + clns_pkg::PHASE_W'(1);
               if (pins_in.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         job_ff <= job;
      end
      if (emit) begin
         pins_ff <= pins_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign pins       = pins_ff;

   a_byte_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && !job_ff.is_init) |-> phase_ff <= clns_pkg::BYTE_LAST_PHASE)
      else $error("byte job ran past its last phase");

   a_init_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && job_ff.is_init) |-> phase_ff <= clns_pkg::INIT_LAST_PHASE)
      else $error("init job ran past its last phase");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && pins_in.last) |=> (state_ff == S_IDLE && out_valid_ff))
      else $error("run did not end after its final update");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> (!out_valid_ff || $past(out_valid_ff)))
      else $error("update produced while no job was running");

endmodule

FILE: src/char_lcd_nibble_sequencer.sv
// Channel | Direction | Handshake         | Contents
// req     | in        | tvalid/tready     | one LCD request
// rsp     | out       | tvalid/tready     | one timed pin update, tlast on the final one
// csr     | in        | we (no wait)      | command byte registers 0..4
//
// A byte request gives 4 updates, init gives 25; unused modes give none.
// The back-end sequencer emits one update a cycle while rsp_tready is high, and
// returns to idle between requests to take the next job from the queue.
// Reset restores the default command bytes and empties the queue and output stage.
// A stalled rsp holds its update; requests keep queueing until the queue is full.
module char_lcd_nibble_sequencer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mode[2:0], byte_value[10:3], cursor_row[12:11], cursor_col[20:13], zero fill
   input  logic [clns_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // reg_select[0], read_write[1], enable_pin[2], bus_nibble[6:3], hold_us[22:7], zero
   output logic [clns_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [clns_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [clns_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   clns_pkg::cfg_type cfg_ff, cfg_in;
   logic              front_valid, front_ready;
   clns_pkg::job_type front_job;
   logic              queue_valid, queue_ready;
   clns_pkg::job_type queue_job;
   clns_pkg::pin_type pins;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            clns_pkg::CSR_FUNCTION_SET:    cfg_in.function_set    = csr_wdata;
            clns_pkg::CSR_DISPLAY_CONTROL: cfg_in.display_control = csr_wdata;
            clns_pkg::CSR_ENTRY_MODE:      cfg_in.entry_mode      = csr_wdata;
            clns_pkg::CSR_CLEAR:           cfg_in.clear           = csr_wdata;
            clns_pkg::CSR_HOME:            cfg_in.home            = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.function_set    <= clns_pkg::RST_FUNCTION_SET;
         cfg_ff.display_control <= clns_pkg::RST_DISPLAY_CONTROL;
         cfg_ff.entry_mode      <= clns_pkg::RST_ENTRY_MODE;
         cfg_ff.clear           <= clns_pkg::RST_CLEAR;
         cfg_ff.home            <= clns_pkg::RST_HOME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clns_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   clns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_job)
   );

   clns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_valid),
      .job_ready  (queue_ready),
      .job        (queue_job),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pins       (pins)
   );

   assign rsp_tdata = {1'b0, pins.hold_us, pins.bus_nibble, pins.enable_pin,
                       pins.read_write, pins.reg_select};
   assign rsp_tlast = pins.last;

endmodule
